FILE: rtl/tbdef_pkg.sv
package tbdef_pkg;

   // Field widths.
   localparam int CMD_W     = 2;
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int WORD_W    = 16;
   localparam int PHASE_W   = 3;
   localparam int STATUS_W  = 2;
   localparam int REASON_W  = 3;
   localparam int CSR_IDX_W = 2;

   // Commands carried by an input transaction.
   localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ABORT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   // Abort kinds reported by the decoder.
   localparam logic [KIND_W-1:0] ABORT_LEADER = 2'd0;
   localparam logic [KIND_W-1:0] ABORT_MID    = 2'd1;

   // Frame phases.
   localparam logic [PHASE_W-1:0] PH_MAGIC0  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_MAGIC1  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ADDR_LO = 3'd2;
   localparam logic [PHASE_W-1:0] PH_ADDR_HI = 3'd3;
   localparam logic [PHASE_W-1:0] PH_LEN_LO  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_LEN_HI  = 3'd5;
   localparam logic [PHASE_W-1:0] PH_DATA    = 3'd6;
   localparam logic [PHASE_W-1:0] PH_CHECK   = 3'd7;

   // Frame status codes.
   localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

   // Failure reasons.
   localparam logic [REASON_W-1:0] REASON_NONE     = 3'd0;
   localparam logic [REASON_W-1:0] REASON_MAGIC    = 3'd1;
   localparam logic [REASON_W-1:0] REASON_LENGTH   = 3'd2;
   localparam logic [REASON_W-1:0] REASON_STORE    = 3'd3;
   localparam logic [REASON_W-1:0] REASON_CHECKSUM = 3'd4;
   localparam logic [REASON_W-1:0] REASON_LEADER   = 3'd5;
   localparam logic [REASON_W-1:0] REASON_MID_BYTE = 3'd6;
   localparam logic [REASON_W-1:0] REASON_FRAMING  = 3'd7;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_LIMIT = 2'd2;

   localparam logic [WORD_W-1:0] LENGTH_LIMIT_RESET = 16'hFFFF;
   localparam logic [WORD_W-1:0] COUNT_MAX          = 16'hFFFF;

   typedef struct packed {
      logic [BYTE_W-1:0] magic_first;
      logic [BYTE_W-1:0] magic_second;
      logic [WORD_W-1:0] length_limit;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] byte_value;
      logic [KIND_W-1:0] abort_kind;
      logic              store_ready;
   } item_type;

   typedef struct packed {
      logic                keep_going;
      logic                payload_valid;
      logic [BYTE_W-1:0]   payload_byte;
      logic [STATUS_W-1:0] frame_status;
      logic [REASON_W-1:0] fail_reason;
      logic [WORD_W-1:0]   frame_address;
      logic [WORD_W-1:0]   frame_length;
      logic [WORD_W-1:0]   bytes_at_fail;
      logic [PHASE_W-1:0]  phase_at_fail;
   } result_type;

endpackage

FILE: rtl/tbdef_intf.sv
// Input channel: one received byte or decoder command per transaction.
interface tbdef_req_if;
   logic                         valid;
   logic                         ready;
   logic [tbdef_pkg::CMD_W-1:0]  cmd;
   logic [tbdef_pkg::BYTE_W-1:0] byte_value;
   logic [tbdef_pkg::KIND_W-1:0] abort_kind;
   logic                         store_ready;

   modport source (output valid, cmd, byte_value, abort_kind, store_ready, input ready);
   modport sink (input valid, cmd, byte_value, abort_kind, store_ready, output ready);
endinterface

// Result channel: one answer per input transaction.
interface tbdef_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           keep_going;
   logic                           payload_valid;
   logic [tbdef_pkg::BYTE_W-1:0]   payload_byte;
   logic [tbdef_pkg::STATUS_W-1:0] frame_status;
   logic [tbdef_pkg::REASON_W-1:0] fail_reason;
   logic [tbdef_pkg::WORD_W-1:0]   frame_address;
   logic [tbdef_pkg::WORD_W-1:0]   frame_length;
   logic [tbdef_pkg::WORD_W-1:0]   bytes_at_fail;
   logic [tbdef_pkg::PHASE_W-1:0]  phase_at_fail;

   modport source (output valid, keep_going, payload_valid, payload_byte, frame_status,
                   fail_reason, frame_address, frame_length, bytes_at_fail,
                   phase_at_fail, input ready);
   modport sink (input valid, keep_going, payload_valid, payload_byte, frame_status,
                 fail_reason, frame_address, frame_length, bytes_at_fail,
                 phase_at_fail, output ready);
endinterface

FILE: rtl/tbdef_csr.sv
module tbdef_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [tbdef_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tbdef_pkg::WORD_W-1:0]      csr_write_data,
   output tbdef_pkg::cfg_type                cfg
);

   tbdef_pkg::cfg_type cfg_ff;
   tbdef_pkg::cfg_type cfg_in;

   // Decode the register index; writes beyond the list change nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tbdef_pkg::CSR_MAGIC_FIRST:
               cfg_in.magic_first = csr_write_data[tbdef_pkg::BYTE_W-1:0];
            tbdef_pkg::CSR_MAGIC_SECOND:
               cfg_in.magic_second = csr_write_data[tbdef_pkg::BYTE_W-1:0];
            tbdef_pkg::CSR_LENGTH_LIMIT:
               cfg_in.length_limit = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_first  <= '0;
         cfg_ff.magic_second <= '0;
         cfg_ff.length_limit <= tbdef_pkg::LENGTH_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/tbdef_frame.sv
module tbdef_frame (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  tbdef_pkg::item_type   item,
   input  tbdef_pkg::cfg_type    cfg,
   output tbdef_pkg::result_type result
);

   logic [tbdef_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [tbdef_pkg::WORD_W-1:0]  address_ff, address_in;
   logic [tbdef_pkg::WORD_W-1:0]  length_ff, length_in;
   logic [tbdef_pkg::WORD_W-1:0]  remaining_ff, remaining_in;
   logic [tbdef_pkg::BYTE_W-1:0]  xor_ff, xor_in;
   logic [tbdef_pkg::WORD_W-1:0]  count_ff, count_in;

   logic [tbdef_pkg::WORD_W-1:0]  count_inc;
   logic [tbdef_pkg::WORD_W-1:0]  remaining_dec;
   logic [tbdef_pkg::WORD_W-1:0]  header_length;
   logic                          fail;
   logic [tbdef_pkg::REASON_W-1:0] reason;
   logic                          clear;

   // Saturating count and the payload countdown.
   assign count_inc = (count_ff == tbdef_pkg::COUNT_MAX) ? count_ff : count_ff + 16'd1;
   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - 16'd1 : remaining_ff;
   assign header_length = {item.byte_value, length_ff[tbdef_pkg::BYTE_W-1:0]};

   // Next frame state and the answer for this transaction.
   always_comb begin
      phase_in     = phase_ff;
      address_in   = address_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      xor_in       = xor_ff;
      count_in     = count_ff;
      fail         = 1'b0;
      reason       = tbdef_pkg::REASON_NONE;
      clear        = 1'b0;
      result       = '0;
      result.keep_going = 1'b1;

      unique case (item.cmd)
         tbdef_pkg::CMD_ABORT: begin
            fail = 1'b1;
            case (item.abort_kind)
               tbdef_pkg::ABORT_LEADER: reason = tbdef_pkg::REASON_LEADER;
               tbdef_pkg::ABORT_MID:    reason = tbdef_pkg::REASON_MID_BYTE;
               default:                 reason = tbdef_pkg::REASON_FRAMING;
            endcase
         end
         tbdef_pkg::CMD_RESTART: clear = 1'b1;
         tbdef_pkg::CMD_BYTE: begin
            unique case (phase_ff)
               tbdef_pkg::PH_MAGIC0: begin
                  if (item.byte_value != cfg.magic_first) begin
                     fail   = 1'b1;
                     reason = tbdef_pkg::REASON_MAGIC;
                  end else begin
                     count_in = count_inc;
                     phase_in = tbdef_pkg::PH_MAGIC1;
                  end
               end
               tbdef_pkg::PH_MAGIC1: begin
                  if (item.byte_value != cfg.magic_second) begin
                     fail   = 1'b1;
                     reason = tbdef_pkg::REASON_MAGIC;
                  end else begin
                     count_in = count_inc;
                     phase_in = tbdef_pkg::PH_ADDR_LO;
                  end
               end
               tbdef_pkg::PH_ADDR_LO: begin
                  address_in = {8'd0, item.byte_value};
                  count_in   = count_inc;
                  phase_in   = tbdef_pkg::PH_ADDR_HI;
               end
               tbdef_pkg::PH_ADDR_HI: begin
                  address_in = {item.byte_value, address_ff[tbdef_pkg::BYTE_W-1:0]};
                  count_in   = count_inc;
                  phase_in   = tbdef_pkg::PH_LEN_LO;
               end
               tbdef_pkg::PH_LEN_LO: begin
                  length_in = {8'd0, item.byte_value};
                  count_in  = count_inc;
                  phase_in  = tbdef_pkg::PH_LEN_HI;
               end
               tbdef_pkg::PH_LEN_HI: begin
                  // The length check takes priority over the store check.
                  length_in = header_length;
                  if (header_length == '0 || header_length > cfg.length_limit) begin
                     fail   = 1'b1;
                     reason = tbdef_pkg::REASON_LENGTH;
                  end else if (!item.store_ready) begin
                     fail   = 1'b1;
                     reason = tbdef_pkg::REASON_STORE;
                  end else begin
                     count_in     = count_inc;
                     remaining_in = header_length;
                     xor_in       = '0;
                     phase_in     = tbdef_pkg::PH_DATA;
                  end
               end
               tbdef_pkg::PH_DATA: begin
                  result.payload_valid = 1'b1;
                  result.payload_byte  = item.byte_value;
                  xor_in       = xor_ff ^ item.byte_value;
                  count_in     = count_inc;
                  remaining_in = remaining_dec;
                  if (remaining_dec == '0) begin
                     phase_in = tbdef_pkg::PH_CHECK;
                  end
               end
               default: begin
                  if (item.byte_value == xor_ff) begin
                     result.keep_going    = 1'b0;
                     result.frame_status  = tbdef_pkg::STATUS_OK;
                     result.frame_address = address_ff;
                     result.frame_length  = length_ff;
                     clear = 1'b1;
                  end else begin
                     fail   = 1'b1;
                     reason = tbdef_pkg::REASON_CHECKSUM;
                  end
               end
            endcase
         end
         default: ;
      endcase

      // A failure reports a snapshot taken before the frame is cleared.
      if (fail) begin
         result.keep_going    = 1'b0;
         result.frame_status  = tbdef_pkg::STATUS_ERROR;
         result.fail_reason   = reason;
         result.frame_address = address_in;
         result.frame_length  = length_in;
         result.bytes_at_fail = count_ff;
         result.phase_at_fail = phase_ff;
         clear = 1'b1;
      end

      if (clear) begin
         phase_in     = tbdef_pkg::PH_MAGIC0;
         address_in   = '0;
         length_in    = '0;
         remaining_in = '0;
         xor_in       = '0;
         count_in     = '0;
      end
   end

   // Frame state advances only when a transaction is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tbdef_pkg::PH_MAGIC0;
         address_ff   <= '0;
         length_ff    <= '0;
         remaining_ff <= '0;
         xor_ff       <= '0;
         count_ff     <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         address_ff   <= address_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
         xor_ff       <= xor_in;
         count_ff     <= count_in;
      end
   end

   // A frame that ends always leaves the block hunting for the first magic byte.
   assert property (@(posedge clock) disable iff (reset)
      fire && !result.keep_going |=> phase_ff == tbdef_pkg::PH_MAGIC0 && count_ff == '0)
      else $error("frame end did not clear the frame state");

   // Payload bytes are only passed while the frame continues.
   assert property (@(posedge clock) disable iff (reset)
      fire && result.payload_valid |->
         result.keep_going && result.frame_status == tbdef_pkg::STATUS_BUSY)
      else $error("payload byte reported on a finished frame");

   // The data phase is never entered with nothing left to receive.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == tbdef_pkg::PH_DATA |-> remaining_ff != '0)
      else $error("data phase with zero bytes remaining");

endmodule

FILE: rtl/tape_block_deframer_unit.sv
// Tape block deframer. Each input transaction carries one received byte or a
// decoder command (abort or restart) and produces exactly one result
// transaction, in order. The unit sustains one transaction per clock cycle
// while results are taken: the frame state (phase, address, length,
// countdown, checksum and byte count) is updated by a single pass of logic
// between the input register and the result register. The input side keeps
// accepting while a finished result waits to be taken, stalling only when
// both registers are full and the result is not taken. Configuration
// registers (magic bytes and length limit) are written through the csr_
// port and should be changed only while no transaction is in flight.
module tape_block_deframer_unit (
   input  logic                            clock,
   input  logic                            reset,
   tbdef_req_if.sink                       req_ch,
   tbdef_rsp_if.source                     rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [tbdef_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tbdef_pkg::WORD_W-1:0]    csr_write_data
);

   tbdef_pkg::cfg_type    cfg;
   tbdef_pkg::item_type   item_ff;
   tbdef_pkg::result_type result;
   tbdef_pkg::result_type out_ff;
   logic                  item_valid_ff;
   logic                  out_valid_ff;
   logic                  fire;
   logic                  take;

   tbdef_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Handshake: the result register loads when it is empty or being drained.
   assign fire = item_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !item_valid_ff || fire;
   assign take = req_ch.valid && req_ch.ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         item_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.cmd         <= req_ch.cmd;
         item_ff.byte_value  <= req_ch.byte_value;
         item_ff.abort_kind  <= req_ch.abort_kind;
         item_ff.store_ready <= req_ch.store_ready;
      end
   end

   tbdef_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.keep_going    = out_ff.keep_going;
   assign rsp_ch.payload_valid = out_ff.payload_valid;
   assign rsp_ch.payload_byte  = out_ff.payload_byte;
   assign rsp_ch.frame_status  = out_ff.frame_status;
   assign rsp_ch.fail_reason   = out_ff.fail_reason;
   assign rsp_ch.frame_address = out_ff.frame_address;
   assign rsp_ch.frame_length  = out_ff.frame_length;
   assign rsp_ch.bytes_at_fail = out_ff.bytes_at_fail;
   assign rsp_ch.phase_at_fail = out_ff.phase_at_fail;

   // With both registers full and the output stalled, no new input is taken.
   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && out_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input accepted while the pipeline is full");

   // A pending result that is not taken keeps the frame logic from advancing.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |-> !fire)
      else $error("result register overwritten before it was taken");

   // A result that is not taken stays presented and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> out_valid_ff && $stable(out_ff))
      else $error("pending result dropped or changed before it was taken");

endmodule
